// ===== hw/rtl/msde_pkg.sv =====
// ----------------------------------------------------------------------------
// msde_pkg
// Shared types, character codes and helpers for the dot-stuffing encoder.
// ----------------------------------------------------------------------------
package msde_pkg;

  // Character codes
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // Input request kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Output step slots, sent lowest first
  localparam int STEP_COUNT = 8;
  localparam int STEP_W     = $clog2(STEP_COUNT);

  localparam logic [STEP_W-1:0] STEP_PRE_CR  = 3'd0;  // held CR released
  localparam logic [STEP_W-1:0] STEP_DOT_DBL = 3'd1;  // stuffed dot
  localparam logic [STEP_W-1:0] STEP_BYTE    = 3'd2;  // the body byte
  localparam logic [STEP_W-1:0] STEP_EOL_CR  = 3'd3;  // line end CR
  localparam logic [STEP_W-1:0] STEP_EOL_LF  = 3'd4;  // line end LF
  localparam logic [STEP_W-1:0] STEP_TRM_DOT = 3'd5;  // terminator dot
  localparam logic [STEP_W-1:0] STEP_TRM_CR  = 3'd6;  // terminator CR
  localparam logic [STEP_W-1:0] STEP_TRM_LF  = 3'd7;  // terminator LF

  // Command queue depth (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef logic [STEP_COUNT-1:0] steps_t;

  typedef struct packed {
    steps_t     steps;
    logic [7:0] data;
  } cmd_t;

  // Position of the lowest set step
  function automatic logic [STEP_W-1:0] first_step(input steps_t m);
    logic [STEP_W-1:0] p;
    p = '0;
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        p = STEP_W'(i);
      end
    end
    return p;
  endfunction

  // Byte sent for a step slot
  function automatic logic [7:0] step_byte(input logic [STEP_W-1:0] pos,
                                           input logic [7:0] data);
    logic [7:0] b;
    case (pos)
      STEP_PRE_CR:  b = CH_CR;
      STEP_DOT_DBL: b = CH_DOT;
      STEP_BYTE:    b = data;
      STEP_EOL_CR:  b = CH_CR;
      STEP_EOL_LF:  b = CH_LF;
      STEP_TRM_DOT: b = CH_DOT;
      STEP_TRM_CR:  b = CH_CR;
      STEP_TRM_LF:  b = CH_LF;
      default:      b = data;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/msde_in_if.sv =====
// ----------------------------------------------------------------------------
// msde_in_if
// Input request channel: valid/ready with kind and body byte.
// ----------------------------------------------------------------------------
interface msde_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

// ===== hw/rtl/msde_out_if.sv =====
// ----------------------------------------------------------------------------
// msde_out_if
// Output request channel: valid/ready with one encoded byte.
// ----------------------------------------------------------------------------
interface msde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hw/rtl/msde_front.sv =====
// ----------------------------------------------------------------------------
// msde_front
// Accept requests, track line state and turn each into a step command.
// ----------------------------------------------------------------------------
module msde_front (
  input  logic                clk,
  input  logic                rst,
  msde_in_if.sink             item,
  input  logic                q_full,
  output logic                push,
  output msde_pkg::cmd_t      cmd
);

  logic at_line_start;
  logic cr_pending;
  logic at_line_start_next;
  logic cr_pending_next;
  logic accept;

  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;

  always_comb begin
    cmd.steps          = '0;
    cmd.data           = item.data;
    at_line_start_next = at_line_start;
    cr_pending_next    = cr_pending;
    if (item.kind == msde_pkg::KIND_END) begin
      cmd.steps[msde_pkg::STEP_EOL_CR]  = !at_line_start;
      cmd.steps[msde_pkg::STEP_EOL_LF]  = !at_line_start;
      cmd.steps[msde_pkg::STEP_TRM_DOT] = 1'b1;
      cmd.steps[msde_pkg::STEP_TRM_CR]  = 1'b1;
      cmd.steps[msde_pkg::STEP_TRM_LF]  = 1'b1;
      at_line_start_next = 1'b1;
      cr_pending_next    = 1'b0;
    end else if (item.data == msde_pkg::CH_LF) begin
      // drop any held CR, close the line
      cmd.steps[msde_pkg::STEP_EOL_CR] = 1'b1;
      cmd.steps[msde_pkg::STEP_EOL_LF] = 1'b1;
      at_line_start_next = 1'b1;
      cr_pending_next    = 1'b0;
    end else if (item.data == msde_pkg::CH_CR) begin
      // release the older CR, hold the new one
      cmd.steps[msde_pkg::STEP_PRE_CR] = cr_pending;
      at_line_start_next = 1'b0;
      cr_pending_next    = 1'b1;
    end else begin
      cmd.steps[msde_pkg::STEP_PRE_CR]  = cr_pending;
      cmd.steps[msde_pkg::STEP_DOT_DBL] = at_line_start && (item.data == msde_pkg::CH_DOT);
      cmd.steps[msde_pkg::STEP_BYTE]    = 1'b1;
      at_line_start_next = 1'b0;
      cr_pending_next    = 1'b0;
    end
  end

  // a held CR alone yields nothing
  assign push = accept && (cmd.steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      cr_pending    <= 1'b0;
    end else if (accept) begin
      at_line_start <= at_line_start_next;
      cr_pending    <= cr_pending_next;
    end
  end

endmodule

// ===== hw/rtl/msde_queue.sv =====
// ----------------------------------------------------------------------------
// msde_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module msde_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  msde_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output msde_pkg::cmd_t      head
);

  msde_pkg::cmd_t               entries [msde_pkg::QUEUE_DEPTH];
  logic [msde_pkg::QPTR_W-1:0]  wr_ptr;
  logic [msde_pkg::QPTR_W-1:0]  rd_ptr;
  logic [msde_pkg::QCNT_W-1:0]  count;
  logic [msde_pkg::QCNT_W-1:0]  count_next;

  assign full       = (count == msde_pkg::QCNT_W'(msde_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + msde_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - msde_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + msde_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + msde_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/msde_back.sv =====
// ----------------------------------------------------------------------------
// msde_back
// Walk command steps into an output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module msde_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  msde_pkg::cmd_t      head,
  output logic                pop,
  msde_out_if.source          result
);

  msde_pkg::steps_t             work;
  logic [7:0]                   work_data;
  logic                         work_busy;
  msde_pkg::steps_t             src_steps;
  logic [7:0]                   src_data;
  msde_pkg::steps_t             rest;
  logic [msde_pkg::STEP_W-1:0]  pos;
  logic                         have;
  logic                         load;

  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic                         run_last;

  assign work_busy = (work != '0);
  assign src_steps = work_busy ? work : head.steps;
  assign src_data  = work_busy ? work_data : head.data;
  assign have      = work_busy || head_valid;
  assign rest      = src_steps & (src_steps - msde_pkg::STEP_COUNT'(1));
  assign pos       = msde_pkg::first_step(src_steps);
  assign load      = !out_valid || result.ready;
  assign pop       = load && !work_busy && head_valid;

  always_ff @(posedge clk) begin
    if (load && have) begin
      out_byte  <= msde_pkg::step_byte(pos, src_data);
      run_last  <= (rest == '0);
      work_data <= src_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      work      <= '0;
    end else if (load) begin
      out_valid <= have;
      if (have) begin
        work <= rest;
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.run_last = run_last;

endmodule

// ===== hw/rtl/message_dot_stuffing_encoder.sv =====
// ----------------------------------------------------------------------------
// message_dot_stuffing_encoder
// Mail body encoder: dot stuffing, CR LF line ends and the end terminator.
// ----------------------------------------------------------------------------
// Usage:
//   item   - input requests: kind 0 carries a body byte in data, kind 1 marks
//            the end of the body (data ignored).
//   result - encoded bytes, up to five per request (none for a held CR);
//            run_last flags the last byte caused by an input request.
// Path: with the block idle, an accepted input request is written into the
//   command queue at the accepting edge; its first byte is then loaded into
//   the output register that drives result.
// Throughput: one input request per cycle and one output byte per cycle while
//   result.ready is high. An input request causes up to five bytes; the
//   four-entry command queue and the step walker in the back absorb the extra
//   bytes, and item.ready falls only while that queue is full.
// Reset: rst is synchronous; it empties the queue, drops the output register
//   and returns to line start with no CR held.
// Stall: while result.ready is low the output byte is held, the back stops
//   and the queue keeps filling until full, then item.ready drops.
// ----------------------------------------------------------------------------
module message_dot_stuffing_encoder (
  input  logic        clk,
  input  logic        rst,
  msde_in_if.sink     item,
  msde_out_if.source  result
);

  logic            push;
  msde_pkg::cmd_t  push_cmd;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  msde_pkg::cmd_t  head;

  // classify requests and keep the line state
  msde_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // decouple the two sides
  msde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // emit bytes, one step a cycle while the output is not stalled
  msde_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== hw/rtl/msde_checker.sv =====
// ----------------------------------------------------------------------------
// msde_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module msde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_kind,
  input logic [7:0] in_data,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last
);

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a request that is not a CR byte is later followed by a valid result
  a_emit_seen: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_kind == msde_pkg::KIND_END ||
                              in_data != msde_pkg::CH_CR)) |-> ##2 out_valid)
    else $error("emitting request produced no result");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_byte) && $stable(out_run_last)))
    else $error("result payload changed while stalled");

endmodule

bind message_dot_stuffing_encoder msde_checker u_msde_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .in_kind      (item.kind),
  .in_data      (item.data),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_byte     (result.out_byte),
  .out_run_last (result.run_last)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mail body dot-stuffing encoder. Body bytes and
// end-of-body requests go in. A cycle-free predictor turns each accepted
// request into the encoded bytes it should cause. Every byte that leaves the
// block is compared in order against that list. The run uses random bursts
// on the input and stall patterns on the output.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HOLD_CYCLES   = 60;      // long receiver hold-off
  localparam int RANDOM_ITEMS  = 300;     // rough size of the random phase
  localparam int LIMIT_CYCLES  = 200000;  // generous ceiling for the whole run

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_byte_t;

  logic clk;
  logic rst;

  msde_in_if  in_ch ();
  msde_out_if out_ch ();

  message_dot_stuffing_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  // Predictor state: mirrors the line position and the held CR
  logic      pred_sol;
  logic      cr_held;
  enc_byte_t encoded_q[$];

  // Sender and receiver control
  int  burst_left;
  bit  gaps_on;
  int  recv_mode;
  bit  hold_off_req;

  // Run statistics
  int errors;
  int items_sent;
  int items_accepted;
  int bytes_checked;
  int bodies_closed;
  int input_stall_cycles;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up if the block stops talking to us
  initial begin
    #(4 * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: append the encoded bytes that one accepted request causes.
  // A CR is held back until the next request shows whether a LF follows it.
  // --------------------------------------------------------------------------
  function automatic void put_expected(input logic [7:0] ch);
    enc_byte_t e;
    e.ch   = ch;
    e.last = 1'b0;
    encoded_q.push_back(e);
  endfunction

  function automatic void encode_request(input logic kind, input logic [7:0] data);
    int start;
    start = encoded_q.size();
    if (kind == msde_pkg::KIND_END) begin
      // close a partial line (a held CR is simply dropped), then the terminator
      if (!pred_sol) begin
        put_expected(msde_pkg::CH_CR);
        put_expected(msde_pkg::CH_LF);
      end
      put_expected(msde_pkg::CH_DOT);
      put_expected(msde_pkg::CH_CR);
      put_expected(msde_pkg::CH_LF);
      pred_sol = 1'b1;
      cr_held  = 1'b0;
    end else if (data == msde_pkg::CH_LF) begin
      // bare LF or CR LF both leave as CR LF
      put_expected(msde_pkg::CH_CR);
      put_expected(msde_pkg::CH_LF);
      pred_sol = 1'b1;
      cr_held  = 1'b0;
    end else if (data == msde_pkg::CH_CR) begin
      // release any earlier CR, hold this one
      if (cr_held) put_expected(msde_pkg::CH_CR);
      cr_held  = 1'b1;
      pred_sol = 1'b0;
    end else begin
      if (cr_held) put_expected(msde_pkg::CH_CR);
      if (pred_sol && data == msde_pkg::CH_DOT) put_expected(msde_pkg::CH_DOT);
      put_expected(data);
      cr_held  = 1'b0;
      pred_sol = 1'b0;
    end
    if (encoded_q.size() > start) begin
      encoded_q[encoded_q.size() - 1].last = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the clock edge. Predict on every
  // accepted input request; check every accepted output byte against the
  // oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    enc_byte_t exp_b;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        encode_request(in_ch.kind, in_ch.data);
        items_accepted++;
        if (in_ch.kind == msde_pkg::KIND_END) bodies_closed++;
      end
      if (in_ch.valid && !in_ch.ready) input_stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (encoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual out_byte %02h run_last %0b",
                   $time, out_ch.out_byte, out_ch.run_last);
        end else begin
          exp_b = encoded_q.pop_front();
          bytes_checked++;
          if (out_ch.out_byte !== exp_b.ch) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, exp_b.ch, out_ch.out_byte);
          end
          if (out_ch.run_last !== exp_b.last) begin
            errors++;
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, exp_b.last, out_ch.run_last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: drive result.ready once per cycle. A hold-off request freezes
  // it low until its hold count runs out; else follow the current stall pattern.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int phase;
    hold_left = 0;
    phase     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (recv_mode)
          0:       out_ch.ready <= 1'b1;                          // never stall
          1:       out_ch.ready <= ($urandom_range(0, 9) < 7);    // light stalls
          2:       out_ch.ready <= ((phase % 5) >= 2);            // periodic
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Offer one request and hold it until accepted. Between bursts, drop valid
  // for a random gap when gaps are enabled.
  task automatic send_item(input logic kind, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.data  <= data;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  // Pause the sender until every predicted byte has come out; first let the
  // monitor sample the last accepted request so that it has been predicted
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty body, and end straight after a line feed: terminator only
  task automatic test_terminator_only();
    send_item(msde_pkg::KIND_END, 8'hFF);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
    send_item(msde_pkg::KIND_END, 8'h00);
  endtask

  // Dot at line start is doubled; a second dot or a mid-line dot is not
  task automatic test_dot_stuffing();
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_DOT);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_DOT);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
    send_item(msde_pkg::KIND_BYTE, 8'h61);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_DOT);
    send_item(msde_pkg::KIND_END, 8'h5A);
  endtask

  // Held CR cases: released by a plain byte, CR pairs, CR LF, dot after CR,
  // and a partial line that is only a CR
  task automatic test_held_cr();
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_CR);
    send_item(msde_pkg::KIND_BYTE, 8'h78);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_CR);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_CR);
    send_item(msde_pkg::KIND_BYTE, 8'h79);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_CR);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_CR);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_DOT);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_CR);
    send_item(msde_pkg::KIND_END, 8'hAA);
  endtask

  // Zero byte and the top of the byte range pass through unchanged
  task automatic test_byte_extremes();
    send_item(msde_pkg::KIND_BYTE, 8'h00);
    send_item(msde_pkg::KIND_BYTE, 8'hFF);
    send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
    send_item(msde_pkg::KIND_END, 8'h55);
  endtask

  // Hold the receiver off while a back-to-back stream of expanding requests
  // arrives, so the command queue fills and item.ready drops
  task automatic test_backpressure();
    drain_outputs();
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    burst_left   = 1000;
    for (int i = 0; i < 12; i++) begin
      send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_DOT);
      send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
    end
    send_item(msde_pkg::KIND_END, 8'h00);
    drain_outputs();
  endtask

  // One well-formed message: lines of random bytes with a bias towards the
  // awkward characters, mostly closed by LF, then end of body
  task automatic send_random_message();
    int         lines;
    int         len;
    int         r;
    logic [7:0] ch;
    lines = $urandom_range(0, 4);
    for (int l = 0; l < lines; l++) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 14)      ch = msde_pkg::CH_DOT;
        else if (r < 26) ch = msde_pkg::CH_CR;
        else if (r < 30) ch = msde_pkg::CH_LF;
        else if (r < 33) ch = 8'h00;
        else             ch = 8'($urandom_range(0, 255));
        send_item(msde_pkg::KIND_BYTE, ch);
      end
      if (l < lines - 1 || $urandom_range(0, 1) == 1) begin
        send_item(msde_pkg::KIND_BYTE, msde_pkg::CH_LF);
      end
    end
    send_item(msde_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // Unstructured requests: any byte, and end of body at random points
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      send_item(($urandom_range(0, 7) == 0) ? msde_pkg::KIND_END : msde_pkg::KIND_BYTE,
                8'($urandom_range(0, 255)));
    end
  endtask

  // Mix messages and noise; change the idling scheme now and then and
  // sometimes let the output run dry before carrying on
  task automatic test_random_traffic();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        recv_mode = $urandom_range(0, 3);
        gaps_on   = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else                           send_random_message();
      if ($urandom_range(0, 11) == 0) drain_outputs();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pred_sol           = 1'b1;
    cr_held            = 1'b0;
    burst_left         = 0;
    gaps_on            = 1'b1;
    recv_mode          = 0;
    hold_off_req       = 1'b0;
    errors             = 0;
    items_sent         = 0;
    items_accepted     = 0;
    bytes_checked      = 0;
    bodies_closed      = 0;
    input_stall_cycles = 0;

    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= msde_pkg::KIND_BYTE;
    in_ch.data  <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_terminator_only();
    recv_mode = 1;
    test_dot_stuffing();
    recv_mode = 2;
    test_held_cr();
    recv_mode = 3;
    test_byte_extremes();
    test_backpressure();
    gaps_on   = 1'b1;
    recv_mode = 1;
    test_random_traffic();

    // Let everything out, then let the pipeline settle before the summary
    drain_outputs();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d bodies closed), checked %0d encoded bytes.",
             items_accepted, bodies_closed, bytes_checked);
    $display("Input held off by the block for %0d cycles; %0d mismatches.",
             input_stall_cycles, errors);
    if (errors == 0 && encoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
